### hdl/sctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_pkg
// Types and constants shared by the subcode section timeline repair block.
// ----------------------------------------------------------------------------
package sctr_pkg;

  localparam int ABS_W      = 19;
  localparam int TRK_W      = 7;
  localparam int TT_W       = 19;
  localparam int TYP_W      = 2;
  localparam int TAG_W      = 16;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MAX_OUT    = 64;
  localparam int OUT_N_W    = 7;

  localparam logic [3:0] SETTLE_RUN_RST = 4'd5;
  localparam logic [3:0] MAX_GAP_RST    = 4'd3;
  localparam logic [8:0] OUT_DELAY_RST  = 9'd375;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_GAP_LONG     = 3'd1,
    STAT_GAP_MISMATCH = 3'd2,
    STAT_TRACK_ZERO   = 3'd3,
    STAT_FILL_OVF     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_RUN = 2'd0,
    CFG_MAX_GAP    = 2'd1,
    CFG_OUT_DELAY  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_REPLAY_RD,
    ST_REPLAY_LD,
    ST_PROC,
    ST_FILL,
    ST_KEEP,
    ST_RPR_CHK,
    ST_RPR_RD,
    ST_RPR_WR,
    ST_EMIT_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             ok;
    logic [ABS_W-1:0] abs;
    logic [TRK_W-1:0] trk;
    logic [TT_W-1:0]  tt;
    logic [TYP_W-1:0] typ;
    logic [TAG_W-1:0] tag;
  } sect_t;

  typedef struct packed {
    logic  fill;
    sect_t sect;
  } hold_ent_t;

  typedef struct packed {
    logic             opcode;
    logic             meta_valid;
    logic [ABS_W-1:0] abs_time;
    logic [TRK_W-1:0] track_number;
    logic [TT_W-1:0]  track_time;
    logic [TYP_W-1:0] section_type;
    logic [TAG_W-1:0] payload_tag;
  } in_t;

  typedef struct packed {
    logic [ABS_W-1:0]  out_abs_time;
    logic [TRK_W-1:0]  out_track;
    logic [TT_W-1:0]   out_track_time;
    logic [TYP_W-1:0]  out_type;
    logic [TAG_W-1:0]  out_tag;
    logic              out_valid;
    logic              filler;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

endpackage

### hdl/sctr_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctr_chan_if
// Valid/ready channel carrying one request payload of type T.
// ----------------------------------------------------------------------------
interface sctr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/subcode_section_timeline_repair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subcode_section_timeline_repair
// Settles on a run of consecutive sections, then keeps a hold store in which
// missing sections are filled, late ones dropped and short invalid runs
// repaired; the oldest entries leave once more than output_delay are held.
// ----------------------------------------------------------------------------
// Flow: a push passes through the settle or process state, the fill state once
//   per filler, then keep, repair and emission states; a drain emits the oldest entry.
// Throughput: one request at a time; the hold memory has separate read and
//   write ports, and each state uses at most one of them.
// Reset: control state clears at once; the memories need no clearing pass.
module subcode_section_timeline_repair import sctr_pkg::*; #(
  parameter int HOLD_DEPTH   = 512,
  parameter int MAX_FILL     = 63,
  parameter int SETTLE_DEPTH = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sctr_chan_if.sink   cfg_i,
  sctr_chan_if.sink   sect_i,
  sctr_chan_if.source sect_o
);

  localparam int AW  = $clog2(HOLD_DEPTH);
  localparam int CW  = $clog2(HOLD_DEPTH + 1);
  localparam int SAW = (SETTLE_DEPTH > 1) ? $clog2(SETTLE_DEPTH) : 1;
  localparam int SCW = $clog2(SETTLE_DEPTH + 1);
  localparam int FW  = (MAX_FILL > 1) ? $clog2(MAX_FILL + 1) : 1;
  localparam int EW  = ABS_W + 1;
  localparam int NW  = CW + 8;
  localparam int DLW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  state_e state_q, state_d;

  logic [3:0]            run_q, run_d;
  logic [3:0]            gap_q, gap_d;
  logic [CFG_DATA_W-1:0] delay_q, delay_d;

  logic             settled_q, settled_d;
  logic [SCW-1:0]   scnt_q, scnt_d;
  logic [ABS_W-1:0] slast_q, slast_d;
  logic [SCW-1:0]   rep_n_q, rep_n_d;
  logic [SCW-1:0]   rep_k_q, rep_k_d;
  logic             replay_q, replay_d;
  logic             drain_q, drain_d;

  sect_t            cur_q, cur_d;
  sect_t            lv_q, lv_d;
  sect_t            a_q, a_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    pre_q, pre_d;
  logic [ABS_W-1:0] exp_q, exp_d;
  logic [FW-1:0]    miss_q, miss_d;
  logic [FW-1:0]    fi_q, fi_d;
  logic             keep_q, keep_d;
  logic [TT_W-1:0]  bt_q, bt_d;
  logic [4:0]       rn_q, rn_d;
  logic [4:0]       rj_q, rj_d;
  logic [AW-1:0]    raddr_q, raddr_d;
  status_e          status_q, status_d;
  logic [OUT_N_W-1:0] out_n_q, out_n_d;
  logic             pend_v_q, pend_v_d;
  out_t             pend_q, pend_d;
  logic             out_v_q, out_v_d;
  out_t             out_q, out_d;

  // Hold memory and settle memory, registered read data.
  hold_ent_t hold_mem [HOLD_DEPTH];
  hold_ent_t hrd_q;
  logic      h_we, h_re;
  logic [AW-1:0] h_waddr, h_raddr;
  hold_ent_t h_wdata;

  sect_t     settle_mem [SETTLE_DEPTH];
  sect_t     srd_q;
  logic      s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  sect_t     s_wdata;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(k);
    if (s >= (AW+1)'(HOLD_DEPTH)) begin
      s = s - (AW+1)'(HOLD_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Shared combinational terms.
  logic           in_acc, out_free, can_go;
  logic [CW-1:0]  prefix;
  logic [EW-1:0]  exp_full, diff, cur_abs_e;
  logic           cur_ahead, cur_behind, keep_c, fatal4;
  logic [FW-1:0]  miss_c;
  logic [NW-1:0]  need;
  logic [TT_W-1:0] bt_c, fill_tt, fill_back;
  logic [DLW-1:0] dly_e, dly_c, dly_lim;
  logic           emit_more;
  logic [4:0]     run5, run_c;
  logic           s_consec, s_app, s_go;
  logic [SCW-1:0] s_newcnt;
  logic           rpr_need;
  logic [4:0]     dist_e;
  sect_t          rpr_s;
  sect_t          e_s;
  status_e        stat_new;
  out_t           res;

  assign in_acc   = sect_i.valid && sect_i.ready;
  assign out_free = !out_v_q || sect_o.ready;
  assign can_go   = !pend_v_q || out_free;

  assign prefix    = cnt_q - tail_q;
  assign exp_full  = (prefix != '0) ? EW'(lv_q.abs) + EW'(tail_q) + EW'(1) : '0;
  assign cur_abs_e = EW'(cur_q.abs);
  assign cur_ahead  = cur_q.ok && (cur_abs_e > exp_full);
  assign cur_behind = cur_q.ok && (cur_abs_e < exp_full);
  assign keep_c     = !cur_behind;
  assign diff       = cur_abs_e - exp_full;
  assign miss_c     = cur_ahead ? diff[FW-1:0] : '0;
  assign need       = NW'(cnt_q) + NW'(miss_c) + NW'(keep_c);
  assign fatal4     = (cur_ahead && (diff > EW'(MAX_FILL))) || (need > NW'(HOLD_DEPTH));
  assign bt_c       = (miss_c == '0) ? cur_q.tt :
                      (cur_q.tt >= TT_W'(miss_c)) ? cur_q.tt - TT_W'(miss_c) : '0;
  assign fill_back  = TT_W'(miss_q - fi_q);
  assign fill_tt    = (cur_q.tt >= fill_back) ? cur_q.tt - fill_back : '0;

  assign dly_e     = DLW'(delay_q);
  assign dly_lim   = DLW'(HOLD_DEPTH - 1);
  assign dly_c     = (dly_e == '0) ? DLW'(1) : (dly_e > dly_lim) ? dly_lim : dly_e;
  assign emit_more = (status_q == STAT_OK) && (DLW'(cnt_q) > dly_c) &&
                     (out_n_q < OUT_N_W'(MAX_OUT));

  assign run5     = {1'b0, run_q};
  assign run_c    = (run5 == '0) ? 5'd1 :
                    (run5 > 5'(SETTLE_DEPTH)) ? 5'(SETTLE_DEPTH) : run5;
  assign s_consec = ({1'b0, cur_q.abs} == ({1'b0, slast_q} + EW'(1)));
  assign s_app    = cur_q.ok && (scnt_q != '0) && s_consec &&
                    (scnt_q < SCW'(SETTLE_DEPTH));
  assign s_newcnt = scnt_q + SCW'(1);
  assign s_go     = s_app && (5'(s_newcnt) >= run_c);

  assign rpr_need = cur_q.ok && keep_q && (tail_q != '0);

  // Repair of one entry of the invalid run, j places after the earlier
  // neighbor; the later neighbor lies dist_e places after it.
  assign dist_e = rn_q + 5'd1 - rj_q;
  always_comb begin
    rpr_s     = hrd_q.sect;
    rpr_s.abs = a_q.abs + ABS_W'(rj_q);
    rpr_s.typ = a_q.typ;
    rpr_s.ok  = 1'b1;
    if ((a_q.trk != cur_q.trk) && (bt_q >= TT_W'(dist_e))) begin
      rpr_s.trk = cur_q.trk;
      rpr_s.tt  = bt_q - TT_W'(dist_e);
    end else begin
      rpr_s.trk = a_q.trk;
      rpr_s.tt  = a_q.tt + TT_W'(rj_q);
    end
  end

  assign e_s      = hrd_q.sect;
  assign stat_new = ((status_q == STAT_OK) && (e_s.trk == '0)) ? STAT_TRACK_ZERO : status_q;
  always_comb begin
    res.out_abs_time   = e_s.abs;
    res.out_track      = e_s.trk;
    res.out_track_time = e_s.tt;
    res.out_type       = e_s.typ;
    res.out_tag        = hrd_q.fill ? '0 : e_s.tag;
    res.out_valid      = e_s.ok;
    res.filler         = hrd_q.fill;
    res.status         = stat_new;
    res.last           = 1'b0;
  end

  assign sect_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign sect_o.valid = out_v_q;
  assign sect_o.data  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (sect_i.data.opcode == OP_DRAIN) begin
            state_d = (cnt_q != '0) ? ST_EMIT_RD : ST_IDLE;
          end else if (status_q != STAT_OK) begin
            state_d = ST_IDLE;
          end else if (!settled_q) begin
            state_d = ST_SETTLE;
          end else begin
            state_d = ST_PROC;
          end
        end
      end
      ST_SETTLE:    state_d = s_go ? ST_REPLAY_RD : ST_DONE;
      ST_REPLAY_RD: state_d = ((rep_k_q < rep_n_q) && (status_q == STAT_OK)) ?
                              ST_REPLAY_LD : ST_DONE;
      ST_REPLAY_LD: state_d = ST_PROC;
      ST_PROC: begin
        if (cnt_q == '0 || fatal4) begin
          state_d = ST_NEXT;
        end else if (miss_c != '0) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_KEEP;
        end
      end
      ST_FILL:    state_d = (fi_q == miss_q - FW'(1)) ? ST_KEEP : ST_FILL;
      ST_KEEP:    state_d = ST_RPR_CHK;
      ST_RPR_CHK: begin
        if (pre_q == '0) begin
          state_d = ST_NEXT;
        end else if (rpr_need) begin
          state_d = (tail_q > CW'(gap_q)) ? ST_NEXT : ST_RPR_RD;
        end else begin
          state_d = ST_EMIT_CHK;
        end
      end
      ST_RPR_RD:   state_d = ST_RPR_WR;
      ST_RPR_WR:   state_d = (rj_q == rn_q) ? ST_EMIT_CHK : ST_RPR_RD;
      ST_EMIT_CHK: state_d = emit_more ? ST_EMIT_RD : ST_NEXT;
      ST_EMIT_RD:  state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (can_go) begin
          state_d = drain_q ? ST_DONE : ST_EMIT_CHK;
        end
      end
      ST_NEXT: state_d = replay_q ? ST_REPLAY_RD : ST_DONE;
      ST_DONE: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    run_d     = run_q;
    gap_d     = gap_q;
    delay_d   = delay_q;
    settled_d = settled_q;
    scnt_d    = scnt_q;
    slast_d   = slast_q;
    rep_n_d   = rep_n_q;
    rep_k_d   = rep_k_q;
    replay_d  = replay_q;
    drain_d   = drain_q;
    cur_d     = cur_q;
    lv_d      = lv_q;
    a_d       = a_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    tail_d    = tail_q;
    pre_d     = pre_q;
    exp_d     = exp_q;
    miss_d    = miss_q;
    fi_d      = fi_q;
    keep_d    = keep_q;
    bt_d      = bt_q;
    rn_d      = rn_q;
    rj_d      = rj_q;
    raddr_d   = raddr_q;
    status_d  = status_q;
    out_n_d   = out_n_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    out_v_d   = out_v_q && !sect_o.ready;
    out_d     = out_q;
    h_we      = 1'b0;
    h_re      = 1'b0;
    h_waddr   = slot_of(head_q, cnt_q);
    h_raddr   = head_q;
    h_wdata   = '{fill: 1'b0, sect: cur_q};
    s_we      = 1'b0;
    s_re      = 1'b0;
    s_waddr   = '0;
    s_raddr   = rep_k_q[SAW-1:0];
    s_wdata   = cur_q;

    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_SETTLE_RUN: run_d   = cfg_i.data.value[3:0];
        CFG_MAX_GAP:    gap_d   = cfg_i.data.value[3:0];
        CFG_OUT_DELAY:  delay_d = cfg_i.data.value;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cur_d.ok  = sect_i.data.meta_valid;
          cur_d.abs = sect_i.data.abs_time;
          cur_d.trk = sect_i.data.track_number;
          cur_d.tt  = sect_i.data.track_time;
          cur_d.typ = sect_i.data.section_type;
          cur_d.tag = sect_i.data.payload_tag;
          drain_d   = (sect_i.data.opcode == OP_DRAIN);
          replay_d  = 1'b0;
          out_n_d   = '0;
        end
      end
      ST_SETTLE: begin
        if (!cur_q.ok) begin
          scnt_d = '0;
        end else if (scnt_q == '0) begin
          s_we    = 1'b1;
          s_waddr = '0;
          scnt_d  = SCW'(1);
          slast_d = cur_q.abs;
        end else if (!s_app) begin
          scnt_d = '0;
        end else begin
          s_we    = 1'b1;
          s_waddr = scnt_q[SAW-1:0];
          slast_d = cur_q.abs;
          scnt_d  = s_newcnt;
          if (s_go) begin
            settled_d = 1'b1;
            rep_n_d   = s_newcnt;
            rep_k_d   = '0;
            replay_d  = 1'b1;
            scnt_d    = '0;
          end
        end
      end
      ST_REPLAY_RD: s_re = 1'b1;
      ST_REPLAY_LD: begin
        cur_d    = srd_q;
        cur_d.ok = 1'b1;
        rep_k_d  = rep_k_q + SCW'(1);
      end
      ST_PROC: begin
        a_d    = lv_q;
        pre_d  = prefix;
        keep_d = keep_c;
        miss_d = miss_c;
        fi_d   = '0;
        bt_d   = bt_c;
        exp_d  = exp_full[ABS_W-1:0];
        rn_d   = 5'(tail_q);
        if (cnt_q == '0) begin
          if (cur_q.ok) begin
            h_we   = 1'b1;
            cnt_d  = CW'(1);
            lv_d   = cur_q;
            tail_d = '0;
          end
        end else if (fatal4 && status_q == STAT_OK) begin
          status_d = STAT_FILL_OVF;
        end
      end
      ST_FILL: begin
        h_we              = 1'b1;
        h_wdata.fill      = 1'b1;
        h_wdata.sect.ok   = 1'b1;
        h_wdata.sect.abs  = exp_q + ABS_W'(fi_q);
        h_wdata.sect.trk  = cur_q.trk;
        h_wdata.sect.tt   = fill_tt;
        h_wdata.sect.typ  = cur_q.typ;
        h_wdata.sect.tag  = '0;
        cnt_d             = cnt_q + CW'(1);
        fi_d              = fi_q + FW'(1);
      end
      ST_KEEP: begin
        if (keep_q) begin
          h_we  = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_RPR_CHK: begin
        if (pre_q == '0) begin
          if (status_q == STAT_OK) status_d = STAT_GAP_MISMATCH;
        end else if (rpr_need && (tail_q > CW'(gap_q))) begin
          if (status_q == STAT_OK) status_d = STAT_GAP_LONG;
        end
        rj_d = 5'd1;
        if (cur_q.ok && keep_q) begin
          lv_d   = cur_q;
          tail_d = '0;
        end else if (!cur_q.ok) begin
          tail_d = tail_q + CW'(1);
        end
      end
      ST_RPR_RD: begin
        h_re    = 1'b1;
        h_raddr = slot_of(head_q, pre_q + CW'(rj_q) - CW'(1));
        raddr_d = h_raddr;
      end
      ST_RPR_WR: begin
        h_we    = 1'b1;
        h_waddr = raddr_q;
        h_wdata = '{fill: hrd_q.fill, sect: rpr_s};
        rj_d    = rj_q + 5'd1;
      end
      ST_EMIT_RD: h_re = 1'b1;
      ST_EMIT_LD: begin
        if (can_go) begin
          head_d = slot_of(head_q, CW'(1));
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q == tail_q) begin
            tail_d = tail_q - CW'(1);
          end
          status_d = stat_new;
          out_n_d  = out_n_q + OUT_N_W'(1);
          pend_v_d = 1'b1;
          pend_d   = res;
          if (pend_v_q) begin
            out_v_d = 1'b1;
            out_d   = pend_q;
          end
        end
      end
      ST_DONE: begin
        if (pend_v_q && out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hold_mem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      hrd_q <= hold_mem[h_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      settle_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      srd_q <= settle_mem[s_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      run_q     <= SETTLE_RUN_RST;
      gap_q     <= MAX_GAP_RST;
      delay_q   <= OUT_DELAY_RST;
      settled_q <= 1'b0;
      scnt_q    <= '0;
      rep_n_q   <= '0;
      rep_k_q   <= '0;
      replay_q  <= 1'b0;
      drain_q   <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
      tail_q    <= '0;
      status_q  <= STAT_OK;
      out_n_q   <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      fi_q      <= '0;
      rj_q      <= '0;
    end else begin
      state_q   <= state_d;
      run_q     <= run_d;
      gap_q     <= gap_d;
      delay_q   <= delay_d;
      settled_q <= settled_d;
      scnt_q    <= scnt_d;
      rep_n_q   <= rep_n_d;
      rep_k_q   <= rep_k_d;
      replay_q  <= replay_d;
      drain_q   <= drain_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      tail_q    <= tail_d;
      status_q  <= status_d;
      out_n_q   <= out_n_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      fi_q      <= fi_d;
      rj_q      <= rj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slast_q <= slast_d;
    cur_q   <= cur_d;
    lv_q    <= lv_d;
    a_q     <= a_d;
    pre_q   <= pre_d;
    exp_q   <= exp_d;
    miss_q  <= miss_d;
    keep_q  <= keep_d;
    bt_q    <= bt_d;
    rn_q    <= rn_d;
    raddr_q <= raddr_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(HOLD_DEPTH))
    else $error("hold count beyond store depth");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= cnt_q)
    else $error("invalid tail longer than held entries");

  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q != STAT_OK |=> status_q == $past(status_q))
    else $error("sticky status changed");

  a_settled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |=> settled_q)
    else $error("settled flag dropped");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("pending result left behind at end of request");
`endif

endmodule

### tb/subcode_section_timeline_repair_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subcode_section_timeline_repair_test
// Drives section and drain requests into the timeline repair block, predicts
// every emitted section from a behavioral copy of the settle, fill, drop,
// repair and emission rules, and checks each result field by field.
// ----------------------------------------------------------------------------
module subcode_section_timeline_repair_test;
  import sctr_pkg::*;

  localparam int HOLD_N         = 512;
  localparam int FILL_MAX       = 63;
  localparam int SETTLE_N       = 8;
  localparam int IDLE_PCT       = 16;
  localparam int STALL_LONG     = 400;
  localparam int QUIET_CYCLES   = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  sctr_chan_if #(.T(cfg_t)) cfg_ch ();
  sctr_chan_if #(.T(in_t))  sect_in ();
  sctr_chan_if #(.T(out_t)) sect_out ();

  subcode_section_timeline_repair dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .sect_i (sect_in),
    .sect_o (sect_out)
  );

  // Predicted block state.
  sect_t       hold_mem [HOLD_N];
  bit          fill_mark [HOLD_N];
  int unsigned head_p, held_n;
  sect_t       settle_buf [SETTLE_N];
  int unsigned settle_n;
  bit          is_settled;
  logic [2:0]  sticky;
  int unsigned run_len, gap_lim, delay_len;

  out_t step_out[$];
  out_t expected_sections[$];
  in_t  pending_reqs[$];

  int errs = 0;
  int reqs_taken = 0;
  int stall_req = 0, stall_seen = 0, stall_left = 0;
  int idle_cycles = 0;
  bit quiet;

  // Generator state for well-formed timelines.
  int unsigned tl_abs, cur_trk, cur_tt, cur_typ;

  assign quiet = (reqs_taken >= 150) && (reqs_taken < 200);

  function automatic int unsigned slot_of(int unsigned k);
    return (head_p + k) % HOLD_N;
  endfunction

  function automatic sect_t held_at(int unsigned k);
    return hold_mem[slot_of(k)];
  endfunction

  function automatic void raise_status(logic [2:0] code);
    if (sticky == STAT_OK) sticky = code;
  endfunction

  function automatic void hold_append(sect_t s, bit f);
    int unsigned p;
    if (held_n >= HOLD_N) return;
    p = slot_of(held_n);
    hold_mem[p] = s;
    fill_mark[p] = f;
    held_n++;
  endfunction

  function automatic void emit_oldest();
    sect_t s;
    bit    f;
    out_t  o;
    if (held_n == 0 || step_out.size() >= MAX_OUT) return;
    s = held_at(0);
    f = fill_mark[slot_of(0)];
    head_p = slot_of(1);
    held_n--;
    if (s.trk == 0) raise_status(STAT_TRACK_ZERO);
    o.out_abs_time   = s.abs;
    o.out_track      = s.trk;
    o.out_track_time = s.tt;
    o.out_type       = s.typ;
    o.out_tag        = f ? '0 : s.tag;
    o.out_valid      = s.ok;
    o.filler         = f;
    o.status         = sticky;
    o.last           = 1'b0;
    step_out.push_back(o);
  endfunction

  // Time the next section should carry, from the newest valid held entry.
  function automatic int unsigned next_time();
    int unsigned i;
    i = held_n;
    while (i > 0) begin
      i--;
      if (held_at(i).ok) return held_at(i).abs + (held_n - i);
    end
    return 0;
  endfunction

  function automatic void repair_runs();
    int unsigned n, idx, s, e, k;
    sect_t a, b, r;
    int gap, diff, cur;
    n = held_n;
    if (n == 0) return;
    if (!held_at(0).ok) begin
      raise_status(STAT_GAP_MISMATCH);
      return;
    end
    if (!held_at(n - 1).ok || n < 3) return;
    for (idx = 1; idx < n; idx++) begin
      if (held_at(idx).ok) continue;
      s = idx - 1;
      e = idx + 1;
      while (e < n && !held_at(e).ok) e++;
      if (e >= n) return;
      a = held_at(s);
      b = held_at(e);
      gap = int'(e - s - 1);
      diff = int'(b.abs) - int'(a.abs) - 1;
      if (gap > int'(gap_lim)) begin
        raise_status(STAT_GAP_LONG);
        return;
      end
      if (gap != diff) begin
        raise_status(STAT_GAP_MISMATCH);
        return;
      end
      for (k = s + 1; k < e; k++) begin
        r = held_at(k);
        r.abs = a.abs + (k - s);
        r.typ = a.typ;
        cur = int'(b.tt) - int'(e - k);
        if (a.trk != b.trk && cur >= 0) begin
          r.trk = b.trk;
          r.tt  = cur;
        end else begin
          r.trk = a.trk;
          r.tt  = a.tt + (k - s);
        end
        r.ok = 1'b1;
        hold_mem[slot_of(k)] = r;
      end
    end
  endfunction

  function automatic void absorb(sect_t sec);
    int unsigned exp_t, missing, i, back, lim;
    bit keep;
    sect_t f;
    missing = 0;
    keep = 1'b1;
    if (held_n == 0) begin
      if (sec.ok) hold_append(sec, 1'b0);
      return;
    end
    exp_t = next_time();
    if (sec.ok && sec.abs != exp_t) begin
      if (sec.abs > exp_t) missing = sec.abs - exp_t;
      else keep = 1'b0;
    end
    if (missing > FILL_MAX || held_n + missing + keep > HOLD_N) begin
      raise_status(STAT_FILL_OVF);
      return;
    end
    for (i = 0; i < missing; i++) begin
      back = missing - i;
      f.abs = exp_t + i;
      f.trk = sec.trk;
      f.typ = sec.typ;
      f.tt  = (sec.tt >= back) ? sec.tt - back : 0;
      f.tag = '0;
      f.ok  = 1'b1;
      hold_append(f, 1'b1);
    end
    if (keep) hold_append(sec, 1'b0);
    repair_runs();
    if (sticky != STAT_OK) return;
    lim = (delay_len < 1) ? 1 : (delay_len > HOLD_N - 1) ? HOLD_N - 1 : delay_len;
    while (held_n > lim && step_out.size() < MAX_OUT && sticky == STAT_OK) emit_oldest();
  endfunction

  function automatic void settle_section(sect_t sec);
    int unsigned need, k;
    if (!sec.ok) begin
      settle_n = 0;
      return;
    end
    if (settle_n == 0) begin
      settle_buf[0] = sec;
      settle_n = 1;
      return;
    end
    if (settle_n > SETTLE_N || sec.abs != settle_buf[settle_n - 1].abs + 1) begin
      settle_n = 0;
      return;
    end
    if (settle_n >= SETTLE_N) begin
      settle_n = 0;
      return;
    end
    settle_buf[settle_n] = sec;
    settle_n++;
    need = (run_len < 1) ? 1 : (run_len > SETTLE_N) ? SETTLE_N : run_len;
    if (settle_n >= need) begin
      is_settled = 1'b1;
      for (k = 0; k < settle_n && sticky == STAT_OK; k++) absorb(settle_buf[k]);
      settle_n = 0;
    end
  endfunction

  function automatic void predict(in_t r);
    sect_t s;
    step_out.delete();
    if (r.opcode == OP_DRAIN) begin
      emit_oldest();
    end else if (sticky == STAT_OK) begin
      s.ok  = r.meta_valid;
      s.abs = r.abs_time;
      s.trk = r.track_number;
      s.tt  = r.track_time;
      s.typ = r.section_type;
      s.tag = r.payload_tag;
      if (!is_settled) settle_section(s);
      else absorb(s);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_sections.push_back(step_out[i]);
  endfunction

  task automatic push_sect(bit ok, int unsigned abs_t, int unsigned trk, int unsigned tt,
                           int unsigned typ, int unsigned tag);
    in_t r;
    r.opcode       = OP_PUSH;
    r.meta_valid   = ok;
    r.abs_time     = abs_t;
    r.track_number = trk;
    r.track_time   = tt;
    r.section_type = typ;
    r.payload_tag  = tag;
    predict(r);
    pending_reqs.push_back(r);
  endtask

  task automatic drain_req();
    in_t r;
    r = $urandom;
    r.opcode = OP_DRAIN;
    predict(r);
    pending_reqs.push_back(r);
  endtask

  function automatic int unsigned timeline_next();
    return (is_settled && held_n > 0) ? next_time() : tl_abs;
  endfunction

  task automatic push_next();
    int unsigned a;
    a = timeline_next();
    push_sect(1'b1, a, cur_trk, cur_tt, cur_typ, $urandom_range(65535));
    tl_abs = a + 1;
    cur_tt++;
  endtask

  task automatic push_garbled();
    push_sect(1'b0, $urandom_range(449999), $urandom_range(99), $urandom_range(449999),
              $urandom_range(3), $urandom_range(65535));
  endtask

  // Small track times make the repair fall back to the earlier neighbour.
  task automatic new_track();
    cur_trk = $urandom_range(99, 1);
    cur_tt  = $urandom_range(1) ? $urandom_range(3) : $urandom_range(449000);
    cur_typ = $urandom_range(3);
  endtask

  task automatic run_random(int n, int max_run, int drain_pct);
    int r, m;
    int unsigned a;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < drain_pct) begin
        drain_req();
      end else if (r < drain_pct + 6) begin
        push_sect(1'b1, timeline_next() - $urandom_range(5, 1), cur_trk, cur_tt, cur_typ,
                  $urandom_range(65535));
      end else if (r < drain_pct + 14) begin
        m = $urandom_range(6, 1);
        a = timeline_next() + m;
        cur_tt += m;
        push_sect(1'b1, a, cur_trk, cur_tt, cur_typ, $urandom_range(65535));
        tl_abs = a + 1;
        cur_tt++;
      end else if (r < drain_pct + 24 && max_run > 0) begin
        m = $urandom_range(max_run, 1);
        repeat (m) push_garbled();
        if ($urandom_range(2) == 0) new_track();
        push_next();
      end else if (r < drain_pct + 28) begin
        new_track();
        push_next();
      end else begin
        push_next();
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || sect_in.valid || expected_sections.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, 9'(v)};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SETTLE_RUN: run_len = v & 4'hF;
      CFG_MAX_GAP:    gap_lim = v & 4'hF;
      CFG_OUT_DELAY:  delay_len = v & 9'h1FF;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      errs++;
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (sect_in.valid && sect_in.ready) reqs_taken++;
      if (!sect_in.valid || sect_in.ready) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          sect_in.data  <= pending_reqs.pop_front();
          sect_in.valid <= 1'b1;
        end else begin
          sect_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (sect_out.valid && sect_out.ready) begin
        if (expected_sections.size() == 0) begin
          $error("unexpected section abs_time %0d", sect_out.data.out_abs_time);
          errs++;
        end else begin
          e = expected_sections.pop_front();
          check_field("out_abs_time", e.out_abs_time, sect_out.data.out_abs_time);
          check_field("out_track", e.out_track, sect_out.data.out_track);
          check_field("out_track_time", e.out_track_time, sect_out.data.out_track_time);
          check_field("out_type", e.out_type, sect_out.data.out_type);
          check_field("out_tag", e.out_tag, sect_out.data.out_tag);
          check_field("out_valid", e.out_valid, sect_out.data.out_valid);
          check_field("filler", e.filler, sect_out.data.filler);
          check_field("status", e.status, sect_out.data.status);
          check_field("last", e.last, sect_out.data.last);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        sect_out.ready <= 1'b0;
      end else if (stall_req != stall_seen) begin
        stall_seen <= stall_req;
        stall_left <= STALL_LONG;
        sect_out.ready <= 1'b0;
      end else begin
        sect_out.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles without any handshake on the request, result or config channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((sect_in.valid && sect_in.ready) || (sect_out.valid && sect_out.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL subcode_section_timeline_repair");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sect_in.valid  = 1'b0;
    sect_in.data   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    sect_out.ready = 1'b0;
    run_len    = SETTLE_RUN_RST;
    gap_lim    = MAX_GAP_RST;
    delay_len  = OUT_DELAY_RST;
    is_settled = 1'b0;
    settle_n   = 0;
    head_p     = 0;
    held_n     = 0;
    sticky     = STAT_OK;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_SETTLE_RUN, 1);
    write_reg(CFG_MAX_GAP, 0);
    write_reg(CFG_OUT_DELAY, 1);

    // Directed: empty drain, settle discards, settling on two, fillers with
    // saturated track times, a late section and a drain with content.
    drain_req();
    push_garbled();
    push_sect(1'b1, 0, 1, 0, 0, 0);
    push_sect(1'b1, 449999, 99, 449999, 3, 65535);
    push_sect(1'b1, 262100, 5, 10, 2, 16'h1234);
    push_sect(1'b1, 262101, 5, 11, 2, 16'hEDCB);
    push_sect(1'b1, 262105, 5, 2, 2, 16'h00FF);
    push_sect(1'b1, 262000, 5, 3, 1, 16'hFF00);
    drain_req();
    tl_abs  = 262106;
    cur_trk = 5;
    cur_tt  = 3;
    cur_typ = 2;
    wait_idle();

    write_reg(CFG_SETTLE_RUN, 8);
    write_reg(CFG_MAX_GAP, 4);
    write_reg(CFG_OUT_DELAY, 10);

    // Directed repairs: same track, track change with a time too small for
    // the later neighbour, and track change where the later one fits.
    push_next();
    push_next();
    push_garbled();
    push_garbled();
    push_next();
    push_garbled();
    cur_trk = 7;
    cur_tt  = 0;
    push_next();
    push_garbled();
    push_garbled();
    cur_trk = 8;
    cur_tt  = 50;
    push_next();

    stall_req = 1;
    run_random(110, 4, 5);
    wait_idle();

    write_reg(CFG_SETTLE_RUN, 3);
    write_reg(CFG_MAX_GAP, 15);
    write_reg(CFG_OUT_DELAY, 448);
    run_random(80, 15, 30);

    // Track zero entry, then a gap too wide to fill halts all pushes.
    push_sect(1'b1, timeline_next(), 0, cur_tt, cur_typ, $urandom_range(65535));
    push_sect(1'b1, timeline_next() + 70, cur_trk, cur_tt, cur_typ, 0);
    push_next();
    push_garbled();
    while (held_n > 0) drain_req();
    drain_req();
    wait_idle();

    if (errs == 0 && expected_sections.size() == 0) begin
      $display("PASS subcode_section_timeline_repair");
    end else begin
      $display("FAIL subcode_section_timeline_repair");
    end
    $finish;
  end

endmodule
